### rtl/prrs_pkg.sv
// ----------------------------------------------------------------------------
// prrs_pkg
// Shared types and constants for the pattern reverse/replace stream core.
// ----------------------------------------------------------------------------
`default_nettype none

package prrs_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 64;
    localparam int CFG_ADDR_W = 2;
    localparam int LEN_REG_W  = 5;
    localparam int PAT_BYTES  = 16;
    localparam int PAT_IDX_W  = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_PAT_LO = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PAT_HI = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LEN    = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_last;
        logic              text_end;
    } t_slot;

    typedef struct packed {
        logic shift;
        logic load_pat;
        logic set_rl;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/prrs_cell.sv
// ----------------------------------------------------------------------------
// prrs_cell
// One queue cell: holds a byte with its flags, shifts in its neighbor's
// byte (or its pattern byte on a load) on each shift, and compares the incoming
// byte with its reversed-pattern byte.
`default_nettype none

module prrs_cell (
    input  wire logic                        i_clk,
    input  wire prrs_pkg::t_cell_ctl         i_ctl,
    input  wire prrs_pkg::t_slot             i_prev,
    input  wire logic [prrs_pkg::BYTE_W-1:0] i_pat,
    input  wire logic [prrs_pkg::BYTE_W-1:0] i_rpat,
    output prrs_pkg::t_slot                  o_slot,
    output logic                             o_eq
);

    prrs_pkg::t_slot r_slot;
    prrs_pkg::t_slot n_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.shift) begin
            n_slot.data     = i_ctl.load_pat ? i_pat : i_prev.data;
            n_slot.run_last = i_prev.run_last | i_ctl.set_rl;
            n_slot.text_end = i_prev.text_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;
    assign o_eq   = (i_prev.data == i_rpat);

endmodule

`default_nettype wire

### rtl/pattern_reverse_replace_stream_core.sv
// ----------------------------------------------------------------------------
// pattern_reverse_replace_stream_core
// Streaming find-and-replace of a pattern by its reverse, built as a chain
// of byte cells. Newest byte enters cell 0; pending window bytes sit in the
// low cells, released bytes above them drain from the oldest cell.
// ----------------------------------------------------------------------------
// Throughput: one byte in and one byte out per cycle while neither stream stalls.
// A released byte is popped from the oldest cell into the output register;
//   bytes held in the window wait for the pattern length to fill.
// s_axis_tready drops for one cycle after each config write (reversed
//   pattern table reload) and while all 2*MAX_PATTERN cells are occupied.
// Reset (i_rst_n low, synchronous): queue empty, config registers zero.
`default_nettype none

module pattern_reverse_replace_stream_core #(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write port
    input  wire logic                            i_cfg_we,
    input  wire logic [prrs_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [prrs_pkg::CFG_W-1:0]      i_cfg_wdata,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [prrs_pkg::BYTE_W-1:0]     s_axis_tdata,  // [7:0] in_byte
    input  wire logic                            s_axis_tlast,  // in_last
    // output stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [prrs_pkg::BYTE_W-1:0]          m_axis_tdata,  // [7:0] out_byte
    output logic                                 m_axis_tlast,  // run_last
    output logic                                 m_axis_tuser   // [0] text_end
);

    localparam int DEPTH   = 2 * MAX_PATTERN;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LEN_E_W = $clog2(MAX_PATTERN + 1);
    localparam int BW      = prrs_pkg::BYTE_W;

    logic [prrs_pkg::CFG_W-1:0] r_pat_lo;
    logic [prrs_pkg::CFG_W-1:0] r_pat_hi;
    logic [LEN_E_W-1:0]         r_len;
    logic                       r_busy;
    logic [CNT_W-1:0]           r_count;
    logic [LEN_E_W-1:0]         r_fill;
    logic                       r_ov;
    prrs_pkg::t_slot            r_out;
    logic [BW-1:0]              r_rpat [MAX_PATTERN];
    logic [BW-1:0]              n_rpat [MAX_PATTERN];

    logic [BW-1:0]              w_pat_all [prrs_pkg::PAT_BYTES];
    prrs_pkg::t_slot            w_slot [DEPTH];
    prrs_pkg::t_slot            w_new;
    prrs_pkg::t_slot            w_head;
    logic [DEPTH-1:0]           w_eq;
    logic                       w_acc;
    logic                       w_len0;
    logic                       w_full;
    logic                       w_match;
    logic                       w_hit;
    logic                       w_miss_rel;
    logic                       w_avail;
    logic                       w_pop;
    logic [LEN_E_W-1:0]         w_fill_acc;
    logic [LEN_E_W-1:0]         w_len_new;

    // pattern bytes and reversed table
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_pat_all[k]     = r_pat_lo[k*BW +: BW];
            w_pat_all[k + 8] = r_pat_hi[k*BW +: BW];
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (j < r_len) begin
                n_rpat[j] = w_pat_all[prrs_pkg::PAT_IDX_W'(int'(r_len) - 1 - j)];
            end else begin
                n_rpat[j] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rpat <= n_rpat;
    end

    // match decision
    assign w_acc  = s_axis_tvalid & s_axis_tready;
    assign w_len0 = (r_len == '0);
    assign w_full = !w_len0 && ((r_fill + 1'b1) == r_len);

    always_comb begin
        w_match = 1'b1;
        for (int j = 0; j < DEPTH; j++) begin
            if (j < r_len && !w_eq[j]) begin
                w_match = 1'b0;
            end
        end
    end

    assign w_hit      = w_full & w_match;
    assign w_miss_rel = w_full & ~w_match & ~s_axis_tlast;

    assign w_new.data     = s_axis_tdata;
    assign w_new.run_last = w_len0 | w_hit | s_axis_tlast;
    assign w_new.text_end = s_axis_tlast;

    // cell chain
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        prrs_pkg::t_cell_ctl w_ctl;
        prrs_pkg::t_slot     w_prev;
        logic [BW-1:0]       w_pat;
        logic [BW-1:0]       w_rpat;

        if (j == 0) begin : g_first
            assign w_prev = w_new;
        end else begin : g_next
            assign w_prev = w_slot[j-1];
        end

        if (j < MAX_PATTERN) begin : g_win
            assign w_pat        = w_pat_all[j];
            assign w_rpat       = r_rpat[j];
            assign w_ctl.load_pat = w_hit && (j < r_len);
            assign w_ctl.set_rl = w_miss_rel && (r_len == LEN_E_W'(j + 1));
        end else begin : g_tail
            assign w_pat        = '0;
            assign w_rpat       = '0;
            assign w_ctl.load_pat = 1'b0;
            assign w_ctl.set_rl = 1'b0;
        end

        assign w_ctl.shift = w_acc;

        prrs_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_prev (w_prev),
            .i_pat  (w_pat),
            .i_rpat (w_rpat),
            .o_slot (w_slot[j]),
            .o_eq   (w_eq[j])
        );
    end

    // head of queue and output register
    assign w_head  = w_slot[IDX_W'(r_count - 1'b1)];
    assign w_avail = (r_count > CNT_W'(r_fill));
    assign w_pop   = w_avail & (~r_ov | m_axis_tready);

    always_comb begin
        if (w_len0 || w_hit || s_axis_tlast) begin
            w_fill_acc = '0;
        end else if (w_full) begin
            w_fill_acc = r_len - 1'b1;
        end else begin
            w_fill_acc = r_fill + 1'b1;
        end
    end

    assign w_len_new = (i_cfg_wdata[prrs_pkg::LEN_REG_W-1:0] > MAX_PATTERN)
                     ? LEN_E_W'(MAX_PATTERN)
                     : LEN_E_W'(i_cfg_wdata[prrs_pkg::LEN_REG_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_len    <= '0;
            r_busy   <= 1'b0;
            r_count  <= '0;
            r_fill   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_busy <= i_cfg_we;
            if (w_acc) begin
                r_fill <= w_fill_acc;
            end
            r_count <= r_count + CNT_W'(w_acc) - CNT_W'(w_pop);
            if (w_pop) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    prrs_pkg::REG_PAT_LO: begin
                        r_pat_lo <= i_cfg_wdata;
                    end
                    prrs_pkg::REG_PAT_HI: begin
                        r_pat_hi <= i_cfg_wdata;
                    end
                    prrs_pkg::REG_LEN: begin
                        r_len   <= w_len_new;
                        r_fill  <= '0;
                        r_count <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= w_head;
        end
    end

    assign s_axis_tready = (r_count != CNT_W'(DEPTH)) && !r_busy;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out.data;
    assign m_axis_tlast  = r_out.run_last;
    assign m_axis_tuser  = r_out.text_end;

endmodule

`default_nettype wire

### bench/pattern_reverse_replace_stream_core_tb.sv
// ----------------------------------------------------------------------------
// pattern_reverse_replace_stream_core_tb
// Self-checking bench for the pattern reverse/replace stream core. Text bytes
// are pushed into the slave stream and each output byte is compared with a
// byte-level predictor of the find-and-replace window. A directed part covers
// pass-through, match, flush and config writes on a partly filled window.
// Random texts follow: they are built from pattern copies, broken prefixes
// and noise, and run under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module pattern_reverse_replace_stream_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 500000;
    localparam int TAIL_CYCLES  = 40;
    localparam int SEG_ITEMS    = 24;
    localparam logic [prrs_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [prrs_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [prrs_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [prrs_pkg::BYTE_W-1:0]     s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            rx_ready = 1'b1;
    logic [prrs_pkg::BYTE_W-1:0]     m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            m_axis_tuser;

    // predictor state
    logic [prrs_pkg::CFG_W-1:0]      pat_lo;
    logic [prrs_pkg::CFG_W-1:0]      pat_hi;
    logic [prrs_pkg::LEN_REG_W-1:0]  pat_len;
    logic [prrs_pkg::BYTE_W-1:0]     win [prrs_pkg::PAT_BYTES];
    int                              win_fill;
    prrs_pkg::t_slot                 expected_out [$];

    int gap_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int mismatches = 0;
    int cycles = 0;

    pattern_reverse_replace_stream_core #(
        .MAX_PATTERN(16)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tlast (s_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(rx_ready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            rx_ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [7:0] pat_byte(input int i);
        return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
    endfunction

    function automatic prrs_pkg::t_slot mk_slot(input logic [7:0] b);
        prrs_pkg::t_slot r;
        r.data     = b;
        r.run_last = 1'b0;
        r.text_end = 1'b0;
        return r;
    endfunction

    // outputs caused by one accepted text byte
    function automatic void predict_rewrite(input logic [7:0] b, input logic last);
        prrs_pkg::t_slot res [$];
        prrs_pkg::t_slot r;
        int              len;
        logic            hit;
        len = (int'(pat_len) > prrs_pkg::PAT_BYTES) ? prrs_pkg::PAT_BYTES : int'(pat_len);
        if (len == 0) begin
            r = mk_slot(b);
            r.run_last = 1'b1;
            r.text_end = last;
            expected_out.push_back(r);
            win_fill = 0;
            return;
        end
        if (win_fill >= len) win_fill = 0;
        win[win_fill] = b;
        win_fill++;
        if (win_fill == len) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
                if (win[i] != pat_byte(i)) hit = 1'b0;
            end
            if (hit) begin
                for (int i = 0; i < len; i++) res.push_back(mk_slot(pat_byte(len - 1 - i)));
                win_fill = 0;
            end else begin
                res.push_back(mk_slot(win[0]));
                for (int i = 1; i < len; i++) win[i-1] = win[i];
                win_fill--;
            end
        end
        if (last) begin
            for (int i = 0; i < win_fill; i++) res.push_back(mk_slot(win[i]));
            win_fill = 0;
        end
        if (res.size() > 0) begin
            r = res.pop_back();
            r.run_last = 1'b1;
            r.text_end = last;
            res.push_back(r);
        end
        foreach (res[k]) expected_out.push_back(res[k]);
    endfunction

    always @(posedge i_clk) begin : out_check
        prrs_pkg::t_slot e;
        if (i_rst_n && m_axis_tvalid && rx_ready) begin
            if (expected_out.size() == 0) begin
                $error("unexpected output byte %02h", m_axis_tdata);
                mismatches++;
            end else begin
                e = expected_out.pop_front();
                if (m_axis_tdata !== e.data) begin
                    $error("out_byte: expected %02h, got %02h", e.data, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== e.run_last) begin
                    $error("run_last: expected %0b, got %0b", e.run_last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser !== e.text_end) begin
                    $error("text_end: expected %0b, got %0b", e.text_end, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_rewrite(b, last);
        items_sent++;
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain_and_wait();
        s_tvalid = 1'b0;
        while (expected_out.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [prrs_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [prrs_pkg::CFG_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        case (idx)
            prrs_pkg::REG_PAT_LO: pat_lo = val;
            prrs_pkg::REG_PAT_HI: pat_hi = val;
            prrs_pkg::REG_LEN: begin
                pat_len  = val[prrs_pkg::LEN_REG_W-1:0];
                win_fill = 0;
            end
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic test_passthrough();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_match_and_flush();
        drain_and_wait();
        write_reg(prrs_pkg::REG_PAT_LO, 64'h0000_0000_005A_FF00);
        write_reg(prrs_pkg::REG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(prrs_pkg::REG_LEN, 64'd3);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h22, 1'b1);
    endtask

    // pending bytes are dropped by a length write
    task automatic test_length_write_clears_window();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain_and_wait();
        write_reg(prrs_pkg::REG_LEN, 64'd3);
        send_byte(8'h5A, 1'b1);
    endtask

    // pending bytes survive a pattern write and meet the new bytes
    task automatic test_pattern_write_keeps_window();
        drain_and_wait();
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        drain_and_wait();
        write_reg(prrs_pkg::REG_PAT_LO, 64'h0000_0000_0033_2211);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b1);
    endtask

    task automatic test_unknown_register();
        drain_and_wait();
        write_reg(REG_UNUSED, '1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b1);
    endtask

    task automatic test_random_traffic(input int gap, input int stall, input int budget);
        int                         first;
        int                         seg_start;
        int                         len;
        int                         eff;
        int                         n;
        int                         k;
        logic [7:0]                 sym [2];
        logic [7:0]                 pat [prrs_pkg::PAT_BYTES];
        logic [prrs_pkg::CFG_W-1:0] lo;
        logic [prrs_pkg::CFG_W-1:0] hi;
        logic [prrs_pkg::CFG_W-1:0] lw;
        logic [7:0]                 txt [$];
        int                         extreme [4];
        extreme = '{16, 31, 0, 1};
        drain_and_wait();
        gap_pct   = gap;
        stall_pct = stall;
        first     = items_sent;
        for (int seg = 0; items_sent - first < budget; seg++) begin
            sym[0] = 8'($urandom_range(0, 255));
            sym[1] = 8'($urandom_range(0, 255));
            for (int i = 0; i < prrs_pkg::PAT_BYTES; i++) begin
                pat[i] = ($urandom_range(0, 2) != 0) ? sym[$urandom_range(0, 1)]
                                                     : 8'($urandom_range(0, 255));
                if (i < 8) lo[8*i +: 8] = pat[i];
                else       hi[8*(i-8) +: 8] = pat[i];
            end
            len = (seg < 4) ? extreme[seg] : $urandom_range(0, 31);
            eff = (len > prrs_pkg::PAT_BYTES) ? prrs_pkg::PAT_BYTES : len;
            lw = {$urandom, $urandom};
            lw[prrs_pkg::LEN_REG_W-1:0] = prrs_pkg::LEN_REG_W'(len);
            drain_and_wait();
            write_reg(prrs_pkg::REG_PAT_LO, lo);
            write_reg(prrs_pkg::REG_PAT_HI, hi);
            write_reg(prrs_pkg::REG_LEN, lw);
            seg_start = items_sent;
            while (items_sent - seg_start < SEG_ITEMS && items_sent - first < budget) begin
                txt.delete();
                n = $urandom_range(1, 2 * eff + 6);
                while (txt.size() < n) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            for (int i = 0; i < eff; i++) txt.push_back(pat[i]);
                        end
                        1: begin
                            k = $urandom_range(0, eff);
                            for (int i = 0; i < k; i++) txt.push_back(pat[i]);
                            txt.push_back(8'($urandom_range(0, 255)));
                        end
                        2: begin
                            txt.push_back(eff > 0 ? pat[$urandom_range(0, eff - 1)]
                                                  : sym[$urandom_range(0, 1)]);
                        end
                        default: txt.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                foreach (txt[j]) send_byte(txt[j], j == txt.size() - 1);
            end
        end
    endtask

    initial begin
        pat_lo   = '0;
        pat_hi   = '0;
        pat_len  = '0;
        win_fill = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_passthrough();
        test_match_and_flush();
        test_length_write_clears_window();
        test_pattern_write_keeps_window();
        test_unknown_register();
        test_random_traffic(0, 0, 80);
        test_random_traffic(45, 0, 80);
        test_random_traffic(0, 45, 80);
        test_random_traffic(6, 6, 80);

        drain_and_wait();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/prrs_pkg.sv
rtl/prrs_cell.sv
rtl/pattern_reverse_replace_stream_core.sv
bench/pattern_reverse_replace_stream_core_tb.sv
